// ----- rtl/core/sarv_pkg.sv -----
// ----------------------------------------------------------------------------
// sarv_pkg
// Types and constants shared by the slot allocator with revisions.
// ----------------------------------------------------------------------------
package sarv_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = 6;
	localparam int CNT_W  = 7;
	localparam int WORD_W = 64;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;

	localparam logic [CNT_W-1:0] SLOTS_CNT   = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(64);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_DECLARE  = 3'd0,
		FUNC_AMEND    = 3'd1,
		FUNC_WITHDRAW = 3'd2,
		FUNC_RESOLVE  = 3'd3,
		FUNC_RECLAIM  = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_NO_SLOT = 2'd2,
		STAT_LIMIT   = 2'd3
	} status_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SLOT_W-1:0] slot;
		logic [WORD_W-1:0] spec_word;
		logic              spec_valid;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_out;
		logic [WORD_W-1:0] revision;
		logic [WORD_W-1:0] spec;
		logic [CNT_W-1:0]  occupied;
		logic [CNT_W-1:0]  spanned;
	} result_t;

	// Table state as seen by the execute logic.
	typedef struct packed {
		logic [SLOTS-1:0]  in_use;
		logic [CNT_W-1:0]  free_depth;
		logic [CNT_W-1:0]  spanned;
		logic [CNT_W-1:0]  in_use_count;
		logic [WORD_W-1:0] latest;
		logic [CNT_W-1:0]  limit;
	} state_t;

	// Memory read data after forwarding.
	typedef struct packed {
		logic [WORD_W-1:0] spec;
		logic [WORD_W-1:0] revision;
		logic [SLOT_W-1:0] free_top;
	} rdata_t;

	// Everything the execute logic wants committed for one transaction.
	typedef struct packed {
		logic [CNT_W-1:0]  free_depth;
		logic [CNT_W-1:0]  spanned;
		logic [CNT_W-1:0]  in_use_count;
		logic [WORD_W-1:0] latest;
		logic              use_set;
		logic              use_clr;
		logic              use_clear_all;
		logic [SLOT_W-1:0] use_idx;
		logic              spec_we;
		logic [SLOT_W-1:0] spec_addr;
		logic [WORD_W-1:0] spec_data;
		logic              rev_we;
		logic [SLOT_W-1:0] rev_addr;
		logic [WORD_W-1:0] rev_data;
		logic              free_we;
		logic [SLOT_W-1:0] free_addr;
		logic [SLOT_W-1:0] free_data;
	} update_t;

endpackage

// ----- rtl/core/sarv_ram.sv -----
// ----------------------------------------------------------------------------
// sarv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sarv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/sarv_exec.sv -----
// ----------------------------------------------------------------------------
// sarv_exec
// Decides the result and the state update for the transaction in stage one.
// ----------------------------------------------------------------------------
module sarv_exec (
	input  sarv_pkg::item_t   item,
	input  sarv_pkg::state_t  st,
	input  sarv_pkg::rdata_t  rd,
	output sarv_pkg::result_t res,
	output sarv_pkg::update_t upd
);

	logic                            occ;
	logic [sarv_pkg::CNT_W-1:0]      limit_eff;
	logic [sarv_pkg::WORD_W-1:0]     rev_inc;
	logic [sarv_pkg::SLOT_W-1:0]     target;
	logic                            ok;

	assign occ       = ({1'b0, item.slot} < st.spanned) && st.in_use[item.slot];
	assign limit_eff = (st.limit > sarv_pkg::SLOTS_CNT) ? sarv_pkg::SLOTS_CNT : st.limit;
	assign rev_inc   = st.latest + sarv_pkg::WORD_W'(1);

	always_comb begin
		res.status   = sarv_pkg::STAT_OK;
		res.slot_out = item.slot;
		res.revision = '0;
		res.spec     = '0;

		upd.free_depth    = st.free_depth;
		upd.spanned       = st.spanned;
		upd.in_use_count  = st.in_use_count;
		upd.latest        = st.latest;
		upd.use_set       = 1'b0;
		upd.use_clr       = 1'b0;
		upd.use_clear_all = 1'b0;
		upd.use_idx       = item.slot;
		upd.spec_we       = 1'b0;
		upd.spec_addr     = item.slot;
		upd.spec_data     = item.spec_word;
		upd.rev_we        = 1'b0;
		upd.rev_addr      = item.slot;
		upd.rev_data      = rev_inc;
		upd.free_we       = 1'b0;
		upd.free_addr     = st.free_depth[sarv_pkg::SLOT_W-1:0];
		upd.free_data     = item.slot;

		target = '0;
		ok     = 1'b0;

		case (sarv_pkg::func_t'(item.func))
			sarv_pkg::FUNC_DECLARE: begin
				res.slot_out = '0;
				if (!item.spec_valid) begin
					res.status = sarv_pkg::STAT_INVALID;
				end else begin
					// The revision advances even when the limit refuses the request.
					upd.latest = rev_inc;
					if (st.free_depth != '0) begin
						upd.free_depth = st.free_depth - sarv_pkg::CNT_W'(1);
						target         = rd.free_top;
						ok             = 1'b1;
					end else if (st.spanned >= limit_eff) begin
						res.status = sarv_pkg::STAT_LIMIT;
					end else begin
						target      = st.spanned[sarv_pkg::SLOT_W-1:0];
						upd.spanned = st.spanned + sarv_pkg::CNT_W'(1);
						ok          = 1'b1;
					end
					if (ok) begin
						upd.spec_we      = 1'b1;
						upd.spec_addr    = target;
						upd.rev_we       = 1'b1;
						upd.rev_addr     = target;
						upd.use_set      = 1'b1;
						upd.use_idx      = target;
						upd.in_use_count = st.in_use_count + sarv_pkg::CNT_W'(1);
						res.slot_out     = target;
						res.revision     = rev_inc;
					end
				end
			end
			sarv_pkg::FUNC_AMEND, sarv_pkg::FUNC_WITHDRAW, sarv_pkg::FUNC_RESOLVE: begin
				if (!occ) begin
					res.status = sarv_pkg::STAT_NO_SLOT;
				end else if (sarv_pkg::func_t'(item.func) == sarv_pkg::FUNC_AMEND) begin
					res.revision = rd.revision;
					if (!item.spec_valid) begin
						res.status = sarv_pkg::STAT_INVALID;
					end else if (rd.spec != item.spec_word) begin
						upd.spec_we  = 1'b1;
						upd.rev_we   = 1'b1;
						upd.latest   = rev_inc;
						res.revision = rev_inc;
					end
				end else if (sarv_pkg::func_t'(item.func) == sarv_pkg::FUNC_WITHDRAW) begin
					// The stored revision is never read again before the slot
					// is declared afresh, so it is left as it is.
					upd.use_clr      = 1'b1;
					upd.in_use_count = st.in_use_count - sarv_pkg::CNT_W'(1);
					if (st.free_depth < sarv_pkg::SLOTS_CNT) begin
						upd.free_we    = 1'b1;
						upd.free_depth = st.free_depth + sarv_pkg::CNT_W'(1);
					end
				end else begin
					res.revision = rd.revision;
					res.spec     = rd.spec;
				end
			end
			sarv_pkg::FUNC_RECLAIM: begin
				upd.use_clear_all = 1'b1;
				upd.free_depth    = '0;
				upd.spanned       = '0;
				upd.in_use_count  = '0;
				upd.latest        = '0;
			end
			default: begin
			end
		endcase

		res.occupied = upd.in_use_count;
		res.spanned  = upd.spanned;
	end

endmodule

// ----- rtl/core/slot_allocator_with_revisions_unit.sv -----
// ----------------------------------------------------------------------------
// slot_allocator_with_revisions_unit
// Slot table with a LIFO free list and a global revision counter.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   func, slot, spec_word, spec_valid
// result    out        out_valid / out_ready status, slot_out, revision_out,
//                                            spec_out, occupied_count, spanned_count
// config    in         cfg_valid / cfg_ready cfg_data (slot limit)
//
// One transaction per cycle is sustained while results are not stalled; RAMs are
// read at acceptance, then stage one executes and commits into the result register.
// The three table RAMs each give one read and one write per cycle; a write in the
// acceptance cycle to the address being read is forwarded into stage one.
// Reset clears the control state at once; there is no clearing pass.
// A stalled result holds stage one, and a request is taken only while stage one
// is empty or moving on. The config port is always ready.
// ----------------------------------------------------------------------------
module slot_allocator_with_revisions_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sarv_pkg::FUNC_W-1:0]       func,
	input  logic [sarv_pkg::SLOT_W-1:0]       slot,
	input  logic [sarv_pkg::WORD_W-1:0]       spec_word,
	input  logic                              spec_valid,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sarv_pkg::STAT_W-1:0]       status,
	output logic [sarv_pkg::SLOT_W-1:0]       slot_out,
	output logic [sarv_pkg::WORD_W-1:0]       revision_out,
	output logic [sarv_pkg::WORD_W-1:0]       spec_out,
	output logic [sarv_pkg::CNT_W-1:0]        occupied_count,
	output logic [sarv_pkg::CNT_W-1:0]        spanned_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sarv_pkg::CNT_W-1:0]        cfg_data
);

	logic                          accept;
	logic                          adv;
	logic                          valid_s1;
	sarv_pkg::item_t               item_s1;
	logic                          out_valid_q;
	sarv_pkg::result_t             res_q;

	logic [sarv_pkg::SLOTS-1:0]    in_use_q;
	logic [sarv_pkg::CNT_W-1:0]    free_depth_q;
	logic [sarv_pkg::CNT_W-1:0]    spanned_q;
	logic [sarv_pkg::CNT_W-1:0]    in_use_count_q;
	logic [sarv_pkg::WORD_W-1:0]   latest_q;
	logic [sarv_pkg::CNT_W-1:0]    limit_q;

	sarv_pkg::state_t              st;
	sarv_pkg::rdata_t              rd;
	sarv_pkg::result_t             res;
	sarv_pkg::update_t             upd;

	logic [sarv_pkg::CNT_W-1:0]    depth_after;
	logic [sarv_pkg::SLOT_W-1:0]   free_raddr;
	logic                          spec_we;
	logic                          rev_we;
	logic                          free_we;
	logic [sarv_pkg::WORD_W-1:0]   spec_ram;
	logic [sarv_pkg::WORD_W-1:0]   rev_ram;
	logic [sarv_pkg::SLOT_W-1:0]   free_ram;

	logic                          spec_hit_s1;
	logic                          rev_hit_s1;
	logic                          free_hit_s1;
	logic [sarv_pkg::WORD_W-1:0]   spec_fwd_s1;
	logic [sarv_pkg::WORD_W-1:0]   rev_fwd_s1;
	logic [sarv_pkg::SLOT_W-1:0]   free_fwd_s1;

	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign spec_we = adv && upd.spec_we;
	assign rev_we  = adv && upd.rev_we;
	assign free_we = adv && upd.free_we;

	// The free stack is read at the top it will have once stage one commits.
	assign depth_after = adv ? upd.free_depth : free_depth_q;
	assign free_raddr  = sarv_pkg::SLOT_W'(depth_after - sarv_pkg::CNT_W'(1));

	sarv_ram #(.WIDTH(sarv_pkg::WORD_W), .DEPTH(sarv_pkg::SLOTS)) u_spec_ram (
		.clk   (clk),
		.we    (spec_we),
		.waddr (upd.spec_addr),
		.wdata (upd.spec_data),
		.re    (accept),
		.raddr (slot),
		.rdata (spec_ram)
	);

	sarv_ram #(.WIDTH(sarv_pkg::WORD_W), .DEPTH(sarv_pkg::SLOTS)) u_rev_ram (
		.clk   (clk),
		.we    (rev_we),
		.waddr (upd.rev_addr),
		.wdata (upd.rev_data),
		.re    (accept),
		.raddr (slot),
		.rdata (rev_ram)
	);

	sarv_ram #(.WIDTH(sarv_pkg::SLOT_W), .DEPTH(sarv_pkg::SLOTS)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (upd.free_addr),
		.wdata (upd.free_data),
		.re    (accept),
		.raddr (free_raddr),
		.rdata (free_ram)
	);

	// Stage one payload and forwarding of same-cycle writes.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.func       <= func;
			item_s1.slot       <= slot;
			item_s1.spec_word  <= spec_word;
			item_s1.spec_valid <= spec_valid;
			spec_hit_s1        <= spec_we && (upd.spec_addr == slot);
			rev_hit_s1         <= rev_we && (upd.rev_addr == slot);
			free_hit_s1        <= free_we && (upd.free_addr == free_raddr);
			spec_fwd_s1        <= upd.spec_data;
			rev_fwd_s1         <= upd.rev_data;
			free_fwd_s1        <= upd.free_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	assign rd.spec     = spec_hit_s1 ? spec_fwd_s1 : spec_ram;
	assign rd.revision = rev_hit_s1 ? rev_fwd_s1 : rev_ram;
	assign rd.free_top = free_hit_s1 ? free_fwd_s1 : free_ram;

	assign st.in_use       = in_use_q;
	assign st.free_depth   = free_depth_q;
	assign st.spanned      = spanned_q;
	assign st.in_use_count = in_use_count_q;
	assign st.latest       = latest_q;
	assign st.limit        = limit_q;

	sarv_exec u_exec (
		.item (item_s1),
		.st   (st),
		.rd   (rd),
		.res  (res),
		.upd  (upd)
	);

	// Table state, committed as stage one moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q       <= '0;
			free_depth_q   <= '0;
			spanned_q      <= '0;
			in_use_count_q <= '0;
			latest_q       <= '0;
		end else if (adv) begin
			free_depth_q   <= upd.free_depth;
			spanned_q      <= upd.spanned;
			in_use_count_q <= upd.in_use_count;
			latest_q       <= upd.latest;
			if (upd.use_clear_all) begin
				in_use_q <= '0;
			end else if (upd.use_set) begin
				in_use_q[upd.use_idx] <= 1'b1;
			end else if (upd.use_clr) begin
				in_use_q[upd.use_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sarv_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign slot_out       = res_q.slot_out;
	assign revision_out   = res_q.revision;
	assign spec_out       = res_q.spec;
	assign occupied_count = res_q.occupied;
	assign spanned_count  = res_q.spanned;

	// Every slot ever appended is either in use or on the free stack.
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(free_depth_q + in_use_count_q) == spanned_q)
		else $error("free stack and occupied slots do not account for spanned slots");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(in_use_count_q) == $countones(in_use_q))
		else $error("occupied count differs from the occupancy flags");

	a_declare_rev: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item_s1.func == sarv_pkg::FUNC_DECLARE) && item_s1.spec_valid
		|=> latest_q == ($past(latest_q) + sarv_pkg::WORD_W'(1)))
		else $error("valid declare did not advance the revision counter");

	a_spanned_bound: assert property (@(posedge clk) disable iff (!arst_n)
		spanned_q <= sarv_pkg::SLOTS_CNT)
		else $error("more slots spanned than the table holds");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slot allocator with revisions. A scoreboard
// object keeps its own copy of the slot table, the free stack, the counters
// and the slot limit, and predicts one result for every accepted request.
// Results are compared field by field, in order. The stimulus is a random
// phase, a short directed sequence, then random phases under several slot
// limits, with bursty requests, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import sarv_pkg::*;

	// Function codes that the block must ignore.
	localparam logic [FUNC_W-1:0] FUNC_SPARE5 = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

	localparam int HOLD_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 300000;

	class slot_table_scoreboard;
		logic [WORD_W-1:0] spec_mem [SLOTS];
		logic [WORD_W-1:0] rev_mem [SLOTS];
		bit                in_use [SLOTS];
		logic [SLOT_W-1:0] free_stack [SLOTS];
		int                free_depth;
		int                spanned_cnt;
		int                used_cnt;
		int                limit;
		logic [WORD_W-1:0] latest;
		result_t           expected_q [$];
		int                failures;

		function new();
			foreach (in_use[i])
				in_use[i] = 1'b0;
			free_depth  = 0;
			spanned_cnt = 0;
			used_cnt    = 0;
			limit       = LIMIT_RESET;
			latest      = '0;
			failures    = 0;
		endfunction

		function bit occupied(int s);
			return s < spanned_cnt && in_use[s];
		endfunction

		function void set_limit(logic [CNT_W-1:0] value);
			limit = value;
		endfunction

		// Applies one accepted transaction to the table copy and queues its result.
		function void note_request(item_t req);
			result_t r;
			int      s;
			int      eff_limit;
			int      target;
			bit      granted;
			s           = req.slot;
			r.status    = STAT_OK;
			r.slot_out  = req.slot;
			r.revision  = '0;
			r.spec      = '0;
			case (req.func)
				FUNC_DECLARE: begin
					r.slot_out = '0;
					if (!req.spec_valid) begin
						r.status = STAT_INVALID;
					end else begin
						eff_limit = (limit < SLOTS) ? limit : SLOTS;
						latest    = latest + 1'b1;
						granted   = 1'b1;
						target    = 0;
						if (free_depth > 0) begin
							free_depth--;
							target = free_stack[free_depth];
						end else if (spanned_cnt >= eff_limit) begin
							granted  = 1'b0;
							r.status = STAT_LIMIT;
						end else begin
							target = spanned_cnt;
							spanned_cnt++;
						end
						if (granted) begin
							spec_mem[target] = req.spec_word;
							rev_mem[target]  = latest;
							in_use[target]   = 1'b1;
							used_cnt++;
							r.slot_out = SLOT_W'(target);
							r.revision = latest;
						end
					end
				end
				FUNC_AMEND, FUNC_WITHDRAW, FUNC_RESOLVE: begin
					if (!occupied(s)) begin
						r.status = STAT_NO_SLOT;
					end else if (req.func == FUNC_AMEND) begin
						if (!req.spec_valid) begin
							r.status = STAT_INVALID;
						end else if (spec_mem[s] != req.spec_word) begin
							spec_mem[s] = req.spec_word;
							latest      = latest + 1'b1;
							rev_mem[s]  = latest;
						end
						r.revision = rev_mem[s];
					end else if (req.func == FUNC_WITHDRAW) begin
						in_use[s]  = 1'b0;
						rev_mem[s] = '0;
						if (free_depth < SLOTS) begin
							free_stack[free_depth] = req.slot;
							free_depth++;
						end
						used_cnt--;
					end else begin
						r.revision = rev_mem[s];
						r.spec     = spec_mem[s];
					end
				end
				FUNC_RECLAIM: begin
					foreach (in_use[i])
						in_use[i] = 1'b0;
					free_depth  = 0;
					spanned_cnt = 0;
					used_cnt    = 0;
					latest      = '0;
				end
				default: ;
			endcase
			r.occupied = CNT_W'(used_cnt);
			r.spanned  = CNT_W'(spanned_cnt);
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void report(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			if (got !== want) begin
				failures++;
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, field, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				failures++;
				$display("%0t: result with nothing expected, expected none, actual slot %0d",
					$time, got.slot_out);
				return;
			end
			want = expected_q.pop_front();
			report("status", want.status, got.status);
			report("slot_out", want.slot_out, got.slot_out);
			report("revision_out", want.revision, got.revision);
			report("spec_out", want.spec, got.spec);
			report("occupied_count", want.occupied, got.occupied);
			report("spanned_count", want.spanned, got.spanned);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func = '0;
	logic [SLOT_W-1:0]   slot = '0;
	logic [WORD_W-1:0]   spec_word = '0;
	logic                spec_valid = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STAT_W-1:0]   status;
	logic [SLOT_W-1:0]   slot_out;
	logic [WORD_W-1:0]   revision_out;
	logic [WORD_W-1:0]   spec_out;
	logic [CNT_W-1:0]    occupied_count;
	logic [CNT_W-1:0]    spanned_count;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data = '0;

	slot_table_scoreboard sb = new();

	int hold_requests = 0;
	int holds_taken = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_tick = 0;
	int cycle_count = 0;

	slot_allocator_with_revisions_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.slot           (slot),
		.spec_word      (spec_word),
		.spec_valid     (spec_valid),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.slot_out       (slot_out),
		.revision_out   (revision_out),
		.spec_out       (spec_out),
		.occupied_count (occupied_count),
		.spanned_count  (spanned_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Values sampled here are the ones present just before the edge.
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.status   = status_t'(status);
				got.slot_out = slot_out;
				got.revision = revision_out;
				got.spec     = spec_out;
				got.occupied = occupied_count;
				got.spanned  = spanned_count;
				sb.check_result(got);
			end
			if (in_valid && in_ready)
				sb.note_request('{func: func, slot: slot, spec_word: spec_word,
					spec_valid: spec_valid});
			if (cfg_valid && cfg_ready)
				sb.set_limit(cfg_data);
		end
	end

	// Receiver: changes its stall pattern now and then, and serves hold-off requests.
	always @(posedge clk) begin
		if (holds_taken != hold_requests) begin
			holds_taken = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ((rx_tick % 7) < 4);
				default: out_ready <= $urandom_range(0, 1);
			endcase
		end
		rx_tick++;
		if (rx_tick % 97 == 0)
			rx_mode = $urandom_range(0, 3);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("slot_allocator_with_revisions_unit verification failed");
			$finish;
		end
	end

	function automatic item_t mk(logic [FUNC_W-1:0] f, int s, logic [WORD_W-1:0] w, bit v);
		item_t r;
		r.func       = f;
		r.slot       = SLOT_W'(s);
		r.spec_word  = w;
		r.spec_valid = v;
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// The table copy may lag by one transaction here; it only steers the choice.
	function automatic int pick_occupied();
		int cand [$];
		for (int i = 0; i < SLOTS; i++)
			if (sb.occupied(i))
				cand.insert(cand.size(), i);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	function automatic item_t random_request();
		item_t r;
		int    roll;
		int    pick;
		roll         = $urandom_range(0, 99);
		pick         = pick_occupied();
		r.slot       = SLOT_W'($urandom_range(0, SLOTS - 1));
		r.spec_word  = random_word();
		r.spec_valid = ($urandom_range(0, 9) != 0);
		if (pick >= 0 && $urandom_range(0, 99) < 85)
			r.slot = SLOT_W'(pick);
		if (roll < 30) begin
			r.func = FUNC_DECLARE;
		end else if (roll < 55) begin
			r.func = FUNC_AMEND;
			if (sb.occupied(r.slot) && $urandom_range(0, 3) == 0)
				r.spec_word = sb.spec_mem[r.slot];
		end else if (roll < 70) begin
			r.func = FUNC_WITHDRAW;
		end else if (roll < 92) begin
			r.func = FUNC_RESOLVE;
		end else if (roll < 94) begin
			r.func = FUNC_RECLAIM;
		end else begin
			r.func = FUNC_W'($urandom_range(FUNC_SPARE5, FUNC_SPARE7));
		end
		return r;
	endfunction

	task automatic offer(item_t req);
		in_valid   <= 1'b1;
		func       <= req.func;
		slot       <= req.slot;
		spec_word  <= req.spec_word;
		spec_valid <= req.spec_valid;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic run_random(int count, bit gaps);
		int burst_left;
		int gap;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (gaps && burst_left == 0) begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 20);
			end
			offer(random_request());
			if (burst_left > 0)
				burst_left--;
		end
	endtask

	// Stops offering and waits until every outstanding transaction has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	task automatic write_limit(logic [CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Run with a limit of two so that refusals, reuse and reclaim all show up quickly.
	task automatic directed();
		offer(mk(FUNC_RECLAIM, 42, '0, 1'b0));
		offer(mk(FUNC_DECLARE, 0, 64'h1234, 1'b0));
		offer(mk(FUNC_RESOLVE, 0, '0, 1'b1));
		offer(mk(FUNC_DECLARE, 0, '1, 1'b1));
		offer(mk(FUNC_DECLARE, 63, '0, 1'b1));
		offer(mk(FUNC_DECLARE, 5, 64'hDEAD_BEEF_0000_0001, 1'b1));
		offer(mk(FUNC_AMEND, 0, '1, 1'b1));
		offer(mk(FUNC_AMEND, 0, 64'h0123_4567_89AB_CDEF, 1'b1));
		offer(mk(FUNC_AMEND, 1, 64'h5555_AAAA_5555_AAAA, 1'b0));
		offer(mk(FUNC_RESOLVE, 0, '0, 1'b0));
		offer(mk(FUNC_WITHDRAW, 1, '0, 1'b1));
		offer(mk(FUNC_WITHDRAW, 1, '0, 1'b1));
		offer(mk(FUNC_AMEND, 1, 64'h77, 1'b1));
		offer(mk(FUNC_RESOLVE, 63, '1, 1'b1));
		offer(mk(FUNC_WITHDRAW, 0, '0, 1'b0));
		offer(mk(FUNC_DECLARE, 0, 64'hAAAA_5555_AAAA_5555, 1'b1));
		offer(mk(FUNC_DECLARE, 0, 64'h8000_0000_0000_0000, 1'b1));
		offer(mk(FUNC_DECLARE, 0, 64'h1, 1'b1));
		offer(mk(FUNC_SPARE5, 63, '1, 1'b1));
		offer(mk(FUNC_SPARE6, 21, '0, 1'b0));
		offer(mk(FUNC_SPARE7, 0, '1, 1'b1));
		offer(mk(FUNC_RECLAIM, 0, '1, 1'b1));
		offer(mk(FUNC_RESOLVE, 0, '0, 1'b1));
		offer(mk(FUNC_DECLARE, 0, 64'hFEED, 1'b1));
		offer(mk(FUNC_RESOLVE, 0, '0, 1'b1));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_random(60, 1'b1);
		drain();
		write_limit(7'd2);
		directed();

		drain();
		write_limit(7'd127);
		run_random(110, 1'b1);

		drain();
		write_limit(7'd0);
		run_random(40, 1'b1);

		drain();
		write_limit(7'd1);
		run_random(50, 1'b1);

		// Receiver holds off while requests keep coming, so the input side backs up.
		drain();
		write_limit(7'd64);
		hold_requests++;
		run_random(30, 1'b0);
		run_random(80, 1'b1);

		drain();
		write_limit(CNT_W'($urandom_range(3, 20)));
		run_random(110, 1'b1);

		drain();
		repeat (4) @(posedge clk);
		if (sb.failures == 0 && sb.expected_q.size() == 0)
			$display("slot_allocator_with_revisions_unit verification clean");
		else
			$display("slot_allocator_with_revisions_unit verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/sarv_pkg.sv
rtl/core/sarv_ram.sv
rtl/core/sarv_exec.sv
rtl/core/slot_allocator_with_revisions_unit.sv
verif/testbench.sv
